/* design/snip_pkg.sv */
// ----------------------------------------------------------------------------
// snip_pkg: shared types and constants for the node-information reply parser
// Field codes, status codes, message layout limits and the result record.
// ----------------------------------------------------------------------------
package snip_pkg;

    localparam int MAX_PAYLOAD = 253;
    localparam int POS_W       = 10;

    localparam logic [POS_W-1:0] POS_SAT       = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(MAX_PAYLOAD);
    localparam logic [11:0]      REPLY_TYPE    = 12'hA08;
    localparam logic [2:0]       REQ_TERMS     = 3'd6;
    localparam logic [2:0]       TERMS_SAT     = 3'd7;
    localparam logic [2:0]       TERMS_FIXED   = 3'd4;
    localparam logic [2:0]       TERMS_USER    = 3'd5;
    localparam logic [7:0]       NULL_BYTE     = 8'h00;
    localparam logic [7:0]       CHARS_SAT     = 8'hFF;
    localparam logic [7:0]       LIMIT_RESET   = 8'd64;

    typedef enum logic [3:0] {
        FLD_MFG_VER  = 4'd0,
        FLD_NAME     = 4'd1,
        FLD_MODEL    = 4'd2,
        FLD_HW_VER   = 4'd3,
        FLD_SW_VER   = 4'd4,
        FLD_USER_VER = 4'd5,
        FLD_USER_NAM = 4'd6,
        FLD_DESCR    = 4'd7,
        FLD_BEYOND   = 4'd8
    } t_field;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_LONG   = 2'd1,
        ST_WRONG_TYPE = 2'd2,
        ST_BAD_TERMS  = 2'd3
    } t_status;

    typedef struct packed {
        t_field      field_index;
        logic [7:0]  field_byte;
        logic        is_terminator;
        logic        keep;
        logic        end_of_message;
        t_status     check_status;
    } t_result;

endpackage

/* design/snip_if.sv */
// ----------------------------------------------------------------------------
// snip_if: valid/ready channels of the reply parser
// Byte channel into the parser and labelled-result channel out of it.
// ----------------------------------------------------------------------------
interface snip_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [11:0] message_type;
    logic        last_byte;

    modport source (output valid, data_byte, message_type, last_byte, input ready);
    modport sink   (input valid, data_byte, message_type, last_byte, output ready);
endinterface

interface snip_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_index;
    logic [7:0] field_byte;
    logic       is_terminator;
    logic       keep;
    logic       end_of_message;
    logic [1:0] check_status;

    modport source (output valid, field_index, field_byte, is_terminator, keep,
                    end_of_message, check_status, input ready);
    modport sink   (input valid, field_index, field_byte, is_terminator, keep,
                    end_of_message, check_status, output ready);
endinterface

/* design/snip_field_track.sv */
// ----------------------------------------------------------------------------
// snip_field_track: per-message position state and byte labelling
// Labels the presented byte from the current position state and advances
// the state on each transfer, and clears it after the last byte of a reply.
// ----------------------------------------------------------------------------
module snip_field_track
    import snip_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_message_type,
    input  logic        i_last_byte,
    input  logic [7:0]  i_string_limit,
    output t_result     o_result
);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [2:0]       r_terms, n_terms;
    logic [7:0]       r_chars, n_chars;
    logic             r_type_ok, n_type_ok;
    logic             r_uver,    n_uver;

    logic   first;
    logic   is_null;
    logic   is_string;
    logic   counted;
    logic   type_ok;
    t_field field;
    logic   keep;

    assign first   = (r_pos == '0);
    assign is_null = (i_data_byte == NULL_BYTE);
    assign type_ok = first ? (i_message_type == REPLY_TYPE) : r_type_ok;

    always_comb begin
        field     = FLD_BEYOND;
        is_string = 1'b0;
        keep      = 1'b0;
        n_uver    = r_uver;
        if (first) begin
            field = FLD_MFG_VER;
            keep  = 1'b1;
        end else if (r_terms < TERMS_FIXED) begin
            field     = t_field'(4'd1 + {1'b0, r_terms});
            is_string = 1'b1;
        end else if (r_terms == TERMS_FIXED && !r_uver) begin
            field  = FLD_USER_VER;
            keep   = 1'b1;
            n_uver = 1'b1;
        end else if (r_terms == TERMS_FIXED) begin
            field     = FLD_USER_NAM;
            is_string = 1'b1;
        end else if (r_terms == TERMS_USER) begin
            field     = FLD_DESCR;
            is_string = 1'b1;
        end

        // version bytes are positional and never count as terminators
        counted = is_null && (is_string || field == FLD_BEYOND);
        n_chars = r_chars;
        if (is_string) begin
            if (is_null) begin
                keep    = (i_string_limit != 8'd0);
                n_chars = '0;
            end else begin
                // chars < limit - 1, which is false for a zero limit
                keep = ({1'b0, r_chars} + 9'd1) < {1'b0, i_string_limit};
                if (r_chars != CHARS_SAT) begin
                    n_chars = r_chars + 8'd1;
                end
            end
        end

        n_terms = r_terms;
        if (counted && r_terms != TERMS_SAT) begin
            n_terms = r_terms + 3'd1;
        end
        n_type_ok = type_ok;
        n_pos     = (r_pos != POS_SAT) ? r_pos + POS_W'(1) : r_pos;
    end

    always_comb begin
        o_result.field_index    = field;
        o_result.field_byte     = i_data_byte;
        o_result.is_terminator  = counted;
        o_result.keep           = keep;
        o_result.end_of_message = i_last_byte;
        o_result.check_status   = ST_OK;
        if (i_last_byte) begin
            if (r_pos >= POS_LIMIT) begin
                o_result.check_status = ST_TOO_LONG;
            end else if (!type_ok) begin
                o_result.check_status = ST_WRONG_TYPE;
            end else if (n_terms != REQ_TERMS) begin
                o_result.check_status = ST_BAD_TERMS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_terms   <= '0;
            r_chars   <= '0;
            r_type_ok <= 1'b0;
            r_uver    <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                // drop all message state for the next reply
                r_pos     <= '0;
                r_terms   <= '0;
                r_chars   <= '0;
                r_type_ok <= 1'b0;
                r_uver    <= 1'b0;
            end else begin
                r_pos     <= n_pos;
                r_terms   <= n_terms;
                r_chars   <= n_chars;
                r_type_ok <= n_type_ok;
                r_uver    <= n_uver;
            end
        end
    end

endmodule

/* design/snip_reply_field_parser.sv */
// ----------------------------------------------------------------------------
// snip_reply_field_parser: node-information reply field parser
// Labels each payload byte with its field and checks the reply at its end.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries one payload byte per transfer with the message type and a
//   last-byte mark; o_result carries exactly one labelled result per byte,
//   in order. The status on the result of the last byte gives the verdict:
//   too long, wrong type or wrong terminator count, checked in that order.
//   i_cfg_we/i_cfg_wdata load the per-string buffer limit (reset value 64);
//   write it only while no reply is in flight.
// Latency and throughput:
//   A result appears in the cycle after its byte is transferred. One byte is
//   taken every cycle while o_result.ready stays high: the labelling is a few
//   compares on the position state, and the single result register is
//   refilled in the same cycle it is emptied.
// Reset and stall:
//   Synchronous reset clears the position state and the result valid flag
//   and restores the limit. While the receiver holds o_result.ready low, the
//   result is held and i_byte.ready drops, so no byte is lost.
// ----------------------------------------------------------------------------
module snip_reply_field_parser
    import snip_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    snip_byte_if.sink     i_byte,
    snip_result_if.source o_result
);

    logic [7:0] r_limit;
    logic       r_valid;
    t_result    r_res;
    t_result    n_res;
    logic       accept;

    assign i_byte.ready = !r_valid || o_result.ready;
    assign accept       = i_byte.valid && i_byte.ready;

    snip_field_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_byte.data_byte),
        .i_message_type (i_byte.message_type),
        .i_last_byte    (i_byte.last_byte),
        .i_string_limit (r_limit),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold the payload until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.field_index    = r_res.field_index;
    assign o_result.field_byte     = r_res.field_byte;
    assign o_result.is_terminator  = r_res.is_terminator;
    assign o_result.keep           = r_res.keep;
    assign o_result.end_of_message = r_res.end_of_message;
    assign o_result.check_status   = r_res.check_status;

endmodule

/* design/snip_chk.sv */
// ----------------------------------------------------------------------------
// snip_chk: port-level checks for the reply parser
// Watches both channels of the top level and flags handshake and labelling slips.
// ----------------------------------------------------------------------------
module snip_chk
    import snip_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] i_field_index,
    input  logic [7:0] i_field_byte,
    input  logic       i_is_terminator,
    input  logic       i_keep,
    input  logic       i_end_of_message,
    input  logic [1:0] i_check_status
);

    logic [16:0] out_word;

    assign out_word = {i_field_index, i_field_byte, i_is_terminator, i_keep,
                       i_end_of_message, i_check_status};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(out_word))
        else $error("result changed while stalled");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("transfer in gave no result");

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_end_of_message |-> i_check_status == ST_OK)
        else $error("status reported before end of message");

    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_terminator |->
            i_field_byte == NULL_BYTE && i_field_index != FLD_MFG_VER
            && i_field_index != FLD_USER_VER)
        else $error("terminator flag on a version or non-null byte");

endmodule

bind snip_reply_field_parser snip_chk u_snip_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_byte.valid),
    .i_in_ready       (i_byte.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_field_index    (o_result.field_index),
    .i_field_byte     (o_result.field_byte),
    .i_is_terminator  (o_result.is_terminator),
    .i_keep           (o_result.keep),
    .i_end_of_message (o_result.end_of_message),
    .i_check_status   (o_result.check_status)
);
